### src/sensor_packet_deframer_defines.svh
`ifndef SENSOR_PACKET_DEFRAMER_DEFINES_SVH
`define SENSOR_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor_packet_deframer check failed");

// next-cycle implication
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor_packet_deframer check failed");

`endif

### src/spd_pkg.sv
package spd_pkg;

   localparam logic [7:0] SYNC_CH = 8'h23;
   localparam logic [7:0] CR_CH   = 8'h0D;
   localparam logic [7:0] OFS_CH  = 8'h3D;
   localparam logic [7:0] TYPE_D  = 8'h44;

   localparam logic [11:0] SUM_INIT = 12'h023;

   localparam logic [7:0] CAL_WORD_POS     = 8'd30;
   localparam logic [7:0] HEADING_WORD_POS = 8'd32;
   localparam logic [7:0] HEADING_HI_POS   = HEADING_WORD_POS + 8'd1;

   localparam logic [16:0] HEADING_MAX  = 17'd359;
   localparam logic [16:0] HEADING_WRAP = 17'd360;

   localparam logic [7:0] MIN_HELD = 8'd2;
   localparam logic [7:0] TYPE_POS = 8'd3;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_ARM  = 1'b1;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] ST_GOOD     = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic CSR_MAX_LENGTH     = 1'b0;
   localparam logic CSR_HEADING_OFFSET = 1'b1;

   localparam logic [7:0] MAX_LENGTH_RESET     = 8'd93;
   localparam logic [8:0] HEADING_OFFSET_RESET = 9'd45;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_HUNT,
      MODE_COLLECT
   } rx_mode_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  payload_index;
      logic [1:0]  status;
      logic [7:0]  command_char;
      logic [15:0] heading;
      logic [7:0]  cal_state;
      logic        heading_valid;
      logic        last;
   } result_type;

endpackage

### src/sensor_packet_deframer.sv
// Results of a word are registered and appear in the cycle after it is accepted.
// Throughput while rsp_ready is high: one word per cycle when it yields at most
// one result; a word that completes a payload group yields three results, one per
// cycle, and the next word is taken in the cycle the last of them leaves.
// Reset: synchronous; receiver idle, registers back to 93 and 45, result queue empty.
`include "sensor_packet_deframer_defines.svh"

module sensor_packet_deframer
   import spd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_command_char,
   output logic [15:0] rsp_heading,
   output logic [7:0]  rsp_cal_state,
   output logic        rsp_heading_valid,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   rx_mode_type mode_ff, mode_in;
   logic [7:0]  count_ff, count_in;
   logic [11:0] sum_ff, sum_in;
   logic [7:0]  held0_ff, held0_in, held1_ff, held1_in;
   logic [7:0]  grp_ff [3];
   logic [7:0]  grp_in [3];
   logic [1:0]  gpos_ff, gpos_in;
   logic [7:0]  pcount_ff, pcount_in;
   logic [7:0]  ptype_ff, ptype_in;
   logic [7:0]  cal_ff, cal_in;
   logic [15:0] head_ff, head_in;
   logic [7:0]  max_len_ff;
   logic [8:0]  hofs_ff;

   result_type  q_ff [3];
   result_type  q_in [3];
   logic [1:0]  qcnt_ff;
   logic [1:0]  n_res;

   logic        accept;
   logic        pop;
   logic [7:0]  ca, cb, cc, cd;
   logic [7:0]  dec [3];
   logic [7:0]  idx [3];
   logic [7:0]  chk_hi, chk_lo;
   logic [1:0]  st;
   logic [16:0] hsum;

   assign accept    = req_valid & req_ready;
   assign pop       = rsp_valid & rsp_ready;
   assign req_ready = (qcnt_ff == 2'd0) | ((qcnt_ff == 2'd1) & rsp_ready);

   assign ca = grp_ff[0] - OFS_CH;
   assign cb = grp_ff[1] - OFS_CH;
   assign cc = grp_ff[2] - OFS_CH;
   assign cd = held0_ff - OFS_CH;

   always_comb begin
      // group chars 0..2 are stored, the fourth is the committing byte
      dec[0] = (ca << 2) | (cb >> 4);
      dec[1] = (cb << 4) | (cc >> 2);
      dec[2] = (cc << 6) | cd;
      idx[0] = pcount_ff;
      idx[1] = pcount_ff + 8'd1;
      idx[2] = pcount_ff + 8'd2;
   end

   assign chk_hi = OFS_CH + {2'b00, sum_ff[11:6]};
   assign chk_lo = OFS_CH + {2'b00, sum_ff[5:0]};
   assign hsum   = {1'b0, head_ff} + {8'b0, hofs_ff};

   always_comb begin
      if (count_ff < MIN_HELD) begin
         st = ST_BAD;
      end else if ((held0_ff == chk_hi) && (held1_ff == chk_lo)) begin
         st = ST_GOOD;
      end else begin
         st = ST_BAD;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      grp_in    = grp_ff;
      gpos_in   = gpos_ff;
      pcount_in = pcount_ff;
      ptype_in  = ptype_ff;
      cal_in    = cal_ff;
      head_in   = head_ff;
      n_res     = 2'd0;
      for (int k = 0; k < 3; k++) begin
         q_in[k] = '0;
         q_in[k].command_char = ptype_ff;
      end
      if (accept) begin
         if (req_cmd == CMD_ARM) begin
            mode_in = MODE_HUNT;
         end else begin
            case (mode_ff)
               MODE_HUNT: begin
                  if (req_rx_byte == SYNC_CH) begin
                     mode_in   = MODE_COLLECT;
                     count_in  = '0;
                     sum_in    = SUM_INIT;
                     held0_in  = '0;
                     held1_in  = '0;
                     grp_in    = '{default: '0};
                     gpos_in   = '0;
                     pcount_in = '0;
                     ptype_in  = '0;
                     cal_in    = '0;
                     head_in   = '0;
                  end
               end
               MODE_COLLECT: begin
                  if (req_rx_byte == CR_CH) begin
                     mode_in          = MODE_IDLE;
                     n_res            = 2'd1;
                     q_in[0].kind     = KIND_STATUS;
                     q_in[0].status   = st;
                     q_in[0].last     = 1'b1;
                     if ((st == ST_GOOD) && (ptype_ff == TYPE_D) &&
                         (pcount_ff > HEADING_HI_POS) && (pcount_ff > CAL_WORD_POS)) begin
                        q_in[0].heading_valid = 1'b1;
                        q_in[0].cal_state     = cal_ff;
                        q_in[0].heading       = (hsum > HEADING_MAX) ?
                                                16'(hsum - HEADING_WRAP) : hsum[15:0];
                     end
                  end else if (count_ff >= max_len_ff) begin
                     mode_in        = MODE_IDLE;
                     n_res          = 2'd1;
                     q_in[0].kind   = KIND_STATUS;
                     q_in[0].status = ST_OVERFLOW;
                     q_in[0].last   = 1'b1;
                  end else begin
                     if (count_ff >= MIN_HELD) begin
                        sum_in = sum_ff + {4'b0000, held0_ff};
                        if (count_ff == TYPE_POS) begin
                           ptype_in = held0_ff;
                        end else if (count_ff > TYPE_POS) begin
                           if (gpos_ff != 2'd3) begin
                              grp_in[gpos_ff] = held0_ff;
                              gpos_in         = gpos_ff + 2'd1;
                           end else begin
                              gpos_in   = '0;
                              n_res     = 2'd3;
                              pcount_in = pcount_ff + 8'd3;
                              for (int k = 0; k < 3; k++) begin
                                 q_in[k].kind          = KIND_DATA;
                                 q_in[k].data_byte     = dec[k];
                                 q_in[k].payload_index = idx[k];
                                 if (idx[k] == CAL_WORD_POS) begin
                                    cal_in = dec[k];
                                 end
                                 if (idx[k] == HEADING_WORD_POS) begin
                                    head_in[7:0] = dec[k];
                                 end
                                 if (idx[k] == HEADING_HI_POS) begin
                                    head_in[15:8] = dec[k];
                                 end
                              end
                              q_in[2].last = 1'b1;
                           end
                        end
                        held0_in = held1_ff;
                        held1_in = req_rx_byte;
                     end else if (count_ff[0] == 1'b0) begin
                        held0_in = req_rx_byte;
                     end else begin
                        held1_in = req_rx_byte;
                     end
                     count_in = count_ff + 8'd1;
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         count_ff   <= '0;
         sum_ff     <= SUM_INIT;
         held0_ff   <= '0;
         held1_ff   <= '0;
         grp_ff     <= '{default: '0};
         gpos_ff    <= '0;
         pcount_ff  <= '0;
         ptype_ff   <= '0;
         cal_ff     <= '0;
         head_ff    <= '0;
         max_len_ff <= MAX_LENGTH_RESET;
         hofs_ff    <= HEADING_OFFSET_RESET;
         qcnt_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         held0_ff  <= held0_in;
         held1_ff  <= held1_in;
         grp_ff    <= grp_in;
         gpos_ff   <= gpos_in;
         pcount_ff <= pcount_in;
         ptype_ff  <= ptype_in;
         cal_ff    <= cal_in;
         head_ff   <= head_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_LENGTH:     max_len_ff <= csr_wdata[7:0];
               CSR_HEADING_OFFSET: hofs_ff    <= csr_wdata;
               default:            hofs_ff    <= hofs_ff;
            endcase
         end
         if (accept) begin
            qcnt_ff <= n_res;
         end else if (pop) begin
            qcnt_ff <= qcnt_ff - 2'd1;
         end
      end
   end

   // load on accept, advance on pop
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff <= q_in;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
         q_ff[1] <= q_ff[2];
      end
   end

   assign rsp_valid         = (qcnt_ff != 2'd0);
   assign rsp_kind          = q_ff[0].kind;
   assign rsp_data_byte     = q_ff[0].data_byte;
   assign rsp_payload_index = q_ff[0].payload_index;
   assign rsp_status        = q_ff[0].status;
   assign rsp_command_char  = q_ff[0].command_char;
   assign rsp_heading       = q_ff[0].heading;
   assign rsp_cal_state     = q_ff[0].cal_state;
   assign rsp_heading_valid = q_ff[0].heading_valid;
   assign rsp_last          = q_ff[0].last;

   `SPD_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, qcnt_ff != 2'd2 || !$past(accept))
   `SPD_ASSERT_NOW(a_accept_drained, clock, reset, accept,
      qcnt_ff == 2'd0 || (qcnt_ff == 2'd1 && pop))
   `SPD_ASSERT_NOW(a_final_is_last, clock, reset, pop && qcnt_ff == 2'd1, rsp_last)
   `SPD_ASSERT_NEXT(a_status_ends, clock, reset, pop && rsp_kind == KIND_STATUS,
      mode_ff != MODE_COLLECT || $past(accept))

endmodule
